>>> rtl/mlac_pkg.sv
// shared types, sizes and helper functions for the mip level address calculator
package mlac_pkg;

    localparam int DIM_BITS  = 16;
    localparam int ADDR_BITS = 48;
    localparam int LEN_BITS  = 34;
    localparam int LVL_BITS  = 5;
    localparam int PROD_BITS = 2 * DIM_BITS;
    // one cell per halving; after DIM_BITS halvings both sizes are 1
    localparam int NUM_CELLS = DIM_BITS;

    typedef enum logic [2:0] {
        FMT_DXT1 = 3'd0,
        FMT_DXT3 = 3'd1,
        FMT_DXT5 = 3'd2,
        FMT_BGR  = 3'd3,
        FMT_BGRA = 3'd4,
        FMT_LA   = 3'd5
    } t_fmt;

    typedef struct packed {
        logic [2:0]  format;
        logic [47:0] base_address;
        logic [15:0] top_width;
        logic [15:0] top_height;
        logic [2:0]  face_index;
        logic [31:0] face_length;
        logic [4:0]  level;
    } t_req;

    typedef struct packed {
        logic [47:0] level_address;
        logic [33:0] level_length;
        logic [15:0] level_width;
        logic [15:0] level_height;
        logic        bad_format;
    } t_rsp;

    // data handed from cell to cell
    typedef struct packed {
        logic [ADDR_BITS-1:0] addr;
        logic [DIM_BITS-1:0]  w;
        logic [DIM_BITS-1:0]  h;
        logic [PROD_BITS-1:0] prod;
        t_fmt                 fmt;
        logic [LVL_BITS-1:0]  rem;
        logic                 bad;
    } t_lane;

    // storage units along one edge: 4x4 blocks for dxt, pixels otherwise
    function automatic logic [DIM_BITS-1:0] blocks(input t_fmt f,
                                                   input logic [DIM_BITS-1:0] d);
        logic [DIM_BITS:0] s;
        s = {1'b0, d} + (DIM_BITS+1)'(3);
        if (f == FMT_DXT1 || f == FMT_DXT3 || f == FMT_DXT5) begin
            return DIM_BITS'(s[DIM_BITS:2]);
        end
        return d;
    endfunction

    // unit count times unit bytes, by shift and add
    function automatic logic [LEN_BITS-1:0] unit_len(input t_fmt f,
                                                     input logic [PROD_BITS-1:0] p);
        logic [PROD_BITS+3:0] pe;
        logic [PROD_BITS+3:0] x;
        pe = (PROD_BITS+4)'(p);
        unique case (f) inside
            FMT_DXT1: x = pe << 3;
            FMT_DXT3,
            FMT_DXT5: x = pe << 4;
            FMT_BGR:  x = (pe << 1) + pe;
            FMT_BGRA: x = pe << 2;
            FMT_LA:   x = pe << 1;
            default:  x = '0;
        endcase
        return LEN_BITS'(x);
    endfunction

    // next level size, floor of one
    function automatic logic [DIM_BITS-1:0] half(input logic [DIM_BITS-1:0] d);
        logic [DIM_BITS-1:0] s;
        s = d >> 1;
        return (s == '0) ? DIM_BITS'(1) : s;
    endfunction

endpackage

>>> rtl/mlac_front.sv
// entry cell: format decode, face offset and level zero unit count
module mlac_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  mlac_pkg::t_req i_req,
    output logic           o_valid,
    output mlac_pkg::t_lane o_lane
);
    import mlac_pkg::*;

    logic                 r_valid;
    t_lane                r_lane;
    t_lane                n_lane;
    t_fmt                 w_fmt;
    logic                 w_bad;
    logic [34:0]          w_ofs;
    logic [DIM_BITS-1:0]  w_w;
    logic [DIM_BITS-1:0]  w_h;

    always_comb begin
        w_bad = 1'b0;
        unique case (i_req.format)
            FMT_DXT1: w_fmt = FMT_DXT1;
            FMT_DXT3: w_fmt = FMT_DXT3;
            FMT_DXT5: w_fmt = FMT_DXT5;
            FMT_BGR:  w_fmt = FMT_BGR;
            FMT_BGRA: w_fmt = FMT_BGRA;
            FMT_LA:   w_fmt = FMT_LA;
            default: begin
                w_fmt = FMT_DXT1;
                w_bad = 1'b1;
            end
        endcase
        w_w   = i_req.top_width[DIM_BITS-1:0];
        w_h   = i_req.top_height[DIM_BITS-1:0];
        w_ofs = 35'(i_req.face_index) * 35'(i_req.face_length);
        n_lane.addr = ADDR_BITS'(i_req.base_address) + ADDR_BITS'(w_ofs);
        n_lane.w    = w_w;
        n_lane.h    = w_h;
        n_lane.prod = PROD_BITS'(blocks(w_fmt, w_w)) * PROD_BITS'(blocks(w_fmt, w_h));
        n_lane.fmt  = w_fmt;
        n_lane.rem  = i_req.level;
        n_lane.bad  = w_bad;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
        r_lane <= n_lane;
    end

    assign o_valid = r_valid;
    assign o_lane  = r_lane;

endmodule

>>> rtl/mlac_cell.sv
// one mip step while levels remain: add this level's length, halve sizes, recount units; else pass through
module mlac_cell (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  mlac_pkg::t_lane i_lane,
    output logic            o_valid,
    output mlac_pkg::t_lane o_lane
);
    import mlac_pkg::*;

    logic                r_valid;
    t_lane               r_lane;
    t_lane               n_lane;
    logic [DIM_BITS-1:0] w_w;
    logic [DIM_BITS-1:0] w_h;

    always_comb begin
        n_lane = i_lane;
        w_w    = half(i_lane.w);
        w_h    = half(i_lane.h);
        if (i_lane.rem != '0) begin
            n_lane.addr = i_lane.addr + ADDR_BITS'(unit_len(i_lane.fmt, i_lane.prod));
            n_lane.w    = w_w;
            n_lane.h    = w_h;
            n_lane.prod = PROD_BITS'(blocks(i_lane.fmt, w_w))
                        * PROD_BITS'(blocks(i_lane.fmt, w_h));
            n_lane.rem  = i_lane.rem - LVL_BITS'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
        r_lane <= n_lane;
    end

    assign o_valid = r_valid;
    assign o_lane  = r_lane;

endmodule

>>> rtl/mlac_tail.sv
// last cell: remaining unit-size levels in one step, then the result register
module mlac_tail (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  mlac_pkg::t_lane i_lane,
    output logic            o_done,
    output mlac_pkg::t_rsp  o_rsp
);
    import mlac_pkg::*;

    logic                         r_done;
    t_rsp                         r_rsp;
    t_rsp                         n_rsp;
    logic [LEN_BITS-1:0]          w_len;
    logic [LEN_BITS+LVL_BITS-1:0] w_skip;

    always_comb begin
        // sizes are already 1 here whenever levels remain, so each adds the same
        w_len  = unit_len(i_lane.fmt, i_lane.prod);
        w_skip = (LEN_BITS+LVL_BITS)'(i_lane.rem) * (LEN_BITS+LVL_BITS)'(w_len);
        if (i_lane.bad) begin
            n_rsp            = '0;
            n_rsp.bad_format = 1'b1;
        end else begin
            n_rsp.level_address = 48'(i_lane.addr + ADDR_BITS'(w_skip));
            n_rsp.level_length  = w_len;
            n_rsp.level_width   = 16'(i_lane.w);
            n_rsp.level_height  = 16'(i_lane.h);
            n_rsp.bad_format    = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= i_valid;
        end
        r_rsp <= n_rsp;
    end

    assign o_done = r_done;
    assign o_rsp  = r_rsp;

endmodule

>>> rtl/mip_level_address_calculator_top.sv
// top level of the mip level address calculator: entry cell, cell row, tail
//
// channel   | ports              | handshake
// ----------+--------------------+---------------------------------------------
// request   | start, i_req       | taken on a clock edge with start high, busy low
// result    | o_done, o_rsp      | o_done high one cycle, no back pressure
//
// a request passes from acceptance to o_done through one entry cell, one cell
// per halving step (16 cells, one per bit of the size fields), one tail cell
// busy drops in the cycle the result shows, so the next request may follow at once
// reset (i_rst_n low, synchronous) clears all valid flags and busy
// the result side cannot stall; a result is on o_rsp for exactly one cycle
module mip_level_address_calculator_top (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    input  mlac_pkg::t_req i_req,
    output logic           busy,
    output logic           o_done,
    output mlac_pkg::t_rsp o_rsp
);
    import mlac_pkg::*;

    // request accepted this cycle
    logic  w_take;
    // busy flag covers the whole flight through the row
    logic  r_busy;
    logic  n_busy;

    // valid and lane data between cells, index 0 is the entry cell output
    logic  w_valid [NUM_CELLS+1];
    t_lane w_lane  [NUM_CELLS+1];

    assign w_take = start && !r_busy;

    // entry: face offset, base add and first unit count
    mlac_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_take),
        .i_req   (i_req),
        .o_valid (w_valid[0]),
        .o_lane  (w_lane[0])
    );

    // row of identical step cells, one mip level each
    for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
        mlac_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_valid[g]),
            .i_lane  (w_lane[g]),
            .o_valid (w_valid[g+1]),
            .o_lane  (w_lane[g+1])
        );
    end

    // tail: levels past the last halving, error zeroing, result register
    mlac_tail u_tail (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_valid[NUM_CELLS]),
        .i_lane  (w_lane[NUM_CELLS]),
        .o_done  (o_done),
        .o_rsp   (o_rsp)
    );

    // set on accept, cleared as the request enters the result register
    always_comb begin
        n_busy = r_busy;
        if (w_take) begin
            n_busy = 1'b1;
        end else if (w_valid[NUM_CELLS]) begin
            n_busy = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else begin
            r_busy <= n_busy;
        end
    end

    assign busy = r_busy;

    // a result only ever closes a request that was in flight
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(r_busy))
        else $error("result without a request in flight");

    // an accepted request keeps the block busy
    a_take_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_take |=> r_busy)
        else $error("busy not raised after accept");

    // one request in flight means single-cycle result strobes
    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("back-to-back result strobes");

    // bad format answers with zero address and length
    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_rsp.bad_format) |->
            (o_rsp.level_address == '0 && o_rsp.level_length == '0))
        else $error("bad format result not zeroed");

    // busy drops only when a request reaches the tail
    a_busy_fall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_busy) |-> o_done)
        else $error("busy dropped without a result");

endmodule
